// File: rtl/mtrr_pkg.sv
// package for the modbus tcp read-register engine
// shared codes, protocol constants and the checker result type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtrr_pkg;

    // input word selector (tuser on the slave side)
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_RX_BYTE = 1'b1;

    // result word kind (tuser on the master side)
    localparam logic KIND_REQ_BYTE = 1'b0;
    localparam logic KIND_STATUS   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ID_MISMATCH  = 3'd1,
        ST_BAD_PROTOCOL = 3'd2,
        ST_SHORT_LENGTH = 3'd3,
        ST_TOO_LARGE    = 3'd4,
        ST_EXCEPTION    = 3'd5,
        ST_UNEXPECTED   = 3'd6
    } status_t;

    // protocol constants
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] REQ_LENGTH        = 16'h0006;
    localparam logic [15:0] REQ_COUNT         = 16'h0001;
    localparam logic [7:0]  RSP_BYTE_COUNT    = 8'h02;
    localparam int          EXC_FLAG_BIT      = 7;
    localparam int          HDR_BYTES         = 7;
    localparam int          REQ_BYTES         = 12;
    localparam logic [15:0] MIN_LENGTH        = 16'd2;
    localparam logic [15:0] MIN_VALUE_LENGTH  = 16'd5;

    // apb register map
    localparam int         APB_ADDR_W        = 3;
    localparam logic [2:0] ADDR_UNIT_ADDRESS = 3'h0;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [7:0]  exception_code;
        logic [15:0] register_value;
    } rsp_result_t;

endpackage

`default_nettype wire

// File: rtl/mtrr_rsp.sv
// response checker: walks the mbap header and pdu one byte a cycle while byte_en is set
// and reports at most one status per outstanding read; uses mtrr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtrr_rsp #(
    parameter int PDU_BYTES = 256
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire  [15:0]          start_tid,
    input  wire                  byte_en,
    input  wire  [7:0]           rx_byte,
    output mtrr_pkg::rsp_result_t result
);
    import mtrr_pkg::*;

    localparam int POS_W = $clog2(HDR_BYTES + PDU_BYTES);
    localparam logic [16:0] LEN_MAX = 17'(PDU_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(5);
    localparam logic [POS_W-1:0] POS_UNIT   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_PDU    = POS_W'(HDR_BYTES);

    logic             awaiting_reg, awaiting_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      exp_tid_reg, exp_tid_next;
    logic [7:0]       buf_reg [4];
    logic [7:0]       buf_next [4];

    logic [POS_W-1:0] pdu_idx;
    logic [16:0]      pdu_end;

    assign pdu_idx = pos_reg - POS_PDU;
    // last pdu byte when idx + 2 reaches the header length
    assign pdu_end = 17'(pdu_idx) + 17'd2;

    always_comb
    begin
        awaiting_next = awaiting_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        exp_tid_next  = exp_tid_reg;
        for (int k = 0; k < 4; k++)
        begin
            buf_next[k] = buf_reg[k];
        end
        result = '0;

        if (start)
        begin
            awaiting_next = 1'b1;
            pos_next      = '0;
            len_next      = '0;
            exp_tid_next  = start_tid;
            for (int k = 0; k < 4; k++)
            begin
                buf_next[k] = '0;
            end
        end
        else if (byte_en && awaiting_reg)
        begin
            if (pos_reg < POS_LEN_HI)
            begin
                buf_next[pos_reg[1:0]] = rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg == POS_LEN_HI)
            begin
                len_next = {rx_byte, 8'h00};
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg == POS_LEN_LO)
            begin
                len_next = {len_reg[15:8], rx_byte};
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg == POS_UNIT)
            begin
                // header verdict, first failing check wins
                result.valid = 1'b1;
                if ({buf_reg[0], buf_reg[1]} != exp_tid_reg)
                    result.status = ST_ID_MISMATCH;
                else if (buf_reg[2] != 8'h00 || buf_reg[3] != 8'h00)
                    result.status = ST_BAD_PROTOCOL;
                else if (len_reg < MIN_LENGTH)
                    result.status = ST_SHORT_LENGTH;
                else if ({1'b0, len_reg} > LEN_MAX)
                    result.status = ST_TOO_LARGE;
                else
                    result.valid = 1'b0;

                if (result.valid)
                begin
                    awaiting_next = 1'b0;
                    pos_next      = '0;
                end
                else
                begin
                    pos_next = POS_PDU;
                    for (int k = 0; k < 4; k++)
                    begin
                        buf_next[k] = '0;
                    end
                end
            end
            else
            begin
                if (pdu_idx < POS_W'(4))
                    buf_next[pdu_idx[1:0]] = rx_byte;

                if (pdu_end < {1'b0, len_reg})
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    result.valid  = 1'b1;
                    awaiting_next = 1'b0;
                    pos_next      = '0;
                    if (buf_next[0][EXC_FLAG_BIT])
                    begin
                        result.status         = ST_EXCEPTION;
                        result.exception_code = buf_next[1];
                    end
                    else if (buf_next[0] != FUNC_READ_HOLDING ||
                             buf_next[1] != RSP_BYTE_COUNT ||
                             len_reg < MIN_VALUE_LENGTH)
                    begin
                        result.status = ST_UNEXPECTED;
                    end
                    else
                    begin
                        result.status         = ST_OK;
                        result.register_value = {buf_next[2], buf_next[3]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            pos_reg      <= '0;
            len_reg      <= '0;
            exp_tid_reg  <= '0;
            for (int k = 0; k < 4; k++)
            begin
                buf_reg[k] <= '0;
            end
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            exp_tid_reg  <= exp_tid_next;
            for (int k = 0; k < 4; k++)
            begin
                buf_reg[k] <= buf_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/modbus_tcp_read_register_engine.sv
// top level of the modbus tcp read-holding-register engine
// request serialiser, apb register and output register; uses mtrr_pkg and mtrr_rsp
`timescale 1ns / 1ps
`default_nettype none

// A start word (tuser 0) makes the engine send the 12-byte read-holding-register
// request, one byte per output word, tlast on the last; each start takes the next
// 16-bit transaction number (1 after reset). Response bytes (tuser 1) are taken
// one word per cycle while the input is ready, and give exactly one status word
// (tuser 1, tlast set) when the header fails a check or the last pdu byte arrives;
// bytes with no read outstanding are dropped, and a start abandons any read in
// progress. A status word appears in the cycle after the response byte that ends
// the read. A start holds the input off while the request serialiser fills the
// output register one byte a cycle, pausing while the output stalls.
// The output register holds a finished word until m_axis_tready and the input waits
// while it is full. Write unit_address at byte address 0 while the engine is idle.
module modbus_tcp_read_register_engine #(
    parameter int PDU_BYTES = 256
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // apb configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mtrr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // input words
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [23:0]                      s_axis_tdata,  // register_address, rx_byte
    input  wire                              s_axis_tuser,  // cmd
    // result words
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tx_byte, status, exception_code, register_value, zero pad
    output logic [39:0]                      m_axis_tdata,
    output logic                             m_axis_tuser,  // kind
    output logic                             m_axis_tlast
);
    import mtrr_pkg::*;

    localparam logic [3:0] REQ_LAST = 4'(REQ_BYTES - 1);

    logic        unit_reg, unit_we;
    logic [7:0]  unit_addr_reg;
    logic [15:0] tid_cnt_reg, tid_cnt_next;
    logic        req_active_reg, req_active_next;
    logic [3:0]  req_idx_reg, req_idx_next;
    logic [15:0] req_tid_reg, req_tid_next;
    logic [15:0] req_addr_reg, req_addr_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic        out_last_reg, out_last_next;
    logic [7:0]  out_tx_reg, out_tx_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [7:0]  out_exc_reg, out_exc_next;
    logic [15:0] out_value_reg, out_value_next;

    logic        out_free, in_fire, start, byte_en;
    logic [15:0] in_addr;
    logic [7:0]  in_rx_byte;
    logic [3:0]  sel_idx;
    logic [15:0] sel_tid, sel_addr;
    logic [7:0]  req_byte;
    rsp_result_t rsp;

    // apb port
    assign pready  = 1'b1;
    assign unit_we = psel && penable && pwrite && (paddr == ADDR_UNIT_ADDRESS);
    assign unit_reg = (paddr == ADDR_UNIT_ADDRESS);
    assign prdata  = unit_reg ? {24'h0, unit_addr_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_addr_reg <= '0;
        else if (unit_we)
            unit_addr_reg <= pwdata[7:0];
    end

    // input side
    assign in_addr       = s_axis_tdata[15:0];
    assign in_rx_byte    = s_axis_tdata[23:16];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = out_free && !req_active_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign start         = in_fire && (s_axis_tuser == CMD_START);
    assign byte_en       = in_fire && (s_axis_tuser == CMD_RX_BYTE);

    mtrr_rsp #(
        .PDU_BYTES (PDU_BYTES)
    ) u_rsp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_tid (tid_cnt_reg),
        .byte_en   (byte_en),
        .rx_byte   (in_rx_byte),
        .result    (rsp)
    );

    // request byte select; a start emits byte 0 straight away
    assign sel_idx  = start ? 4'd0 : req_idx_reg;
    assign sel_tid  = start ? tid_cnt_reg : req_tid_reg;
    assign sel_addr = start ? in_addr : req_addr_reg;

    always_comb
    begin
        case (sel_idx)
            4'd0:    req_byte = sel_tid[15:8];
            4'd1:    req_byte = sel_tid[7:0];
            4'd4:    req_byte = REQ_LENGTH[15:8];
            4'd5:    req_byte = REQ_LENGTH[7:0];
            4'd6:    req_byte = unit_addr_reg;
            4'd7:    req_byte = FUNC_READ_HOLDING;
            4'd8:    req_byte = sel_addr[15:8];
            4'd9:    req_byte = sel_addr[7:0];
            4'd10:   req_byte = REQ_COUNT[15:8];
            4'd11:   req_byte = REQ_COUNT[7:0];
            default: req_byte = 8'h00;  // protocol id bytes
        endcase
    end

    always_comb
    begin
        tid_cnt_next    = tid_cnt_reg;
        req_active_next = req_active_reg;
        req_idx_next    = req_idx_reg;
        req_tid_next    = req_tid_reg;
        req_addr_next   = req_addr_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_tx_next     = out_tx_reg;
        out_status_next = out_status_reg;
        out_exc_next    = out_exc_reg;
        out_value_next  = out_value_reg;

        if (start)
        begin
            tid_cnt_next    = tid_cnt_reg + 16'd1;
            req_active_next = 1'b1;
            req_idx_next    = 4'd1;
            req_tid_next    = tid_cnt_reg;
            req_addr_next   = in_addr;
        end
        else if (req_active_reg && out_free && req_idx_reg == REQ_LAST)
        begin
            req_active_next = 1'b0;
        end
        else if (req_active_reg && out_free)
        begin
            req_idx_next = req_idx_reg + 4'd1;
        end

        if (start || (req_active_reg && out_free))
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_REQ_BYTE;
            out_last_next   = (sel_idx == REQ_LAST);
            out_tx_next     = req_byte;
            out_status_next = ST_OK;
            out_exc_next    = '0;
            out_value_next  = '0;
        end
        else if (rsp.valid)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_STATUS;
            out_last_next   = 1'b1;
            out_tx_next     = '0;
            out_status_next = rsp.status;
            out_exc_next    = rsp.exception_code;
            out_value_next  = rsp.register_value;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tid_cnt_reg    <= 16'd1;
            req_active_reg <= 1'b0;
            req_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tid_cnt_reg    <= tid_cnt_next;
            req_active_reg <= req_active_next;
            req_idx_reg    <= req_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_tid_reg    <= req_tid_next;
        req_addr_reg   <= req_addr_next;
        out_kind_reg   <= out_kind_next;
        out_last_reg   <= out_last_next;
        out_tx_reg     <= out_tx_next;
        out_status_reg <= out_status_next;
        out_exc_reg    <= out_exc_next;
        out_value_reg  <= out_value_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'h00, out_value_reg, out_exc_reg, out_status_reg, out_tx_reg};

endmodule

`default_nettype wire

// File: sim/mtrr_checker.sv
// result checker for the modbus tcp read-register engine testbench
// watches the apb port and both word streams, predicts every result word and compares
// depends on mtrr_pkg only
`timescale 1ns / 1ps

module mtrr_checker #(
    parameter int PDU_BYTES = 256
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mtrr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [31:0]                      pwdata,
    input  wire  [31:0]                      prdata,
    input  wire                              pready,
    input  wire                              s_axis_tvalid,
    input  wire                              s_axis_tready,
    input  wire  [23:0]                      s_axis_tdata,   // register_address, rx_byte
    input  wire                              s_axis_tuser,   // cmd
    input  wire                              m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tx_byte, status, exception_code, register_value, zero pad
    input  wire  [39:0]                      m_axis_tdata,
    input  wire                              m_axis_tuser,   // kind
    input  wire                              m_axis_tlast,
    output int                               fail_count,
    output int                               pending
);
    import mtrr_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        status_t     status;
        logic [7:0]  exc_code;
        logic [15:0] reg_value;
    } out_word_t;

    out_word_t   expected_words [$];

    logic [7:0]  unit_id;
    logic [15:0] next_tid;
    logic [15:0] open_tid;
    logic        busy_read;
    int          rx_pos;
    logic [15:0] rsp_len;
    logic [7:0]  pdu_head [4];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void push_word(input logic kind, input logic [7:0] txb,
                                      input logic last, input status_t st,
                                      input logic [7:0] exc, input logic [15:0] val);
        out_word_t w;
        w.kind      = kind;
        w.tx_byte   = txb;
        w.last      = last;
        w.status    = st;
        w.exc_code  = exc;
        w.reg_value = val;
        expected_words.push_back(w);
    endfunction

    function automatic void close_read(input status_t st, input logic [7:0] exc,
                                       input logic [15:0] val);
        busy_read = 1'b0;
        rx_pos    = 0;
        push_word(KIND_STATUS, 8'h00, 1'b1, st, exc, val);
    endfunction

    function automatic void predict_word(input logic cmd, input logic [15:0] addr,
                                         input logic [7:0] b);
        logic [7:0]  req [REQ_BYTES];
        logic [15:0] tid;
        int          idx;
        int          remaining;
        if (cmd == CMD_START)
        begin
            tid      = next_tid;
            next_tid = next_tid + 16'd1;
            req[0]   = tid[15:8];
            req[1]   = tid[7:0];
            req[2]   = 8'h00;
            req[3]   = 8'h00;
            req[4]   = REQ_LENGTH[15:8];
            req[5]   = REQ_LENGTH[7:0];
            req[6]   = unit_id;
            req[7]   = FUNC_READ_HOLDING;
            req[8]   = addr[15:8];
            req[9]   = addr[7:0];
            req[10]  = REQ_COUNT[15:8];
            req[11]  = REQ_COUNT[7:0];
            for (int i = 0; i < REQ_BYTES; i++)
                push_word(KIND_REQ_BYTE, req[i], i == REQ_BYTES - 1, ST_OK, 8'h00, 16'h0000);
            // a start drops any read still in progress
            open_tid  = tid;
            busy_read = 1'b1;
            rx_pos    = 0;
            rsp_len   = 16'h0000;
            pdu_head  = '{default: 8'h00};
        end
        else if (busy_read)
        begin
            if (rx_pos < 4)
            begin
                pdu_head[rx_pos] = b;
                rx_pos++;
            end
            else if (rx_pos == 4)
            begin
                rsp_len = {b, 8'h00};
                rx_pos++;
            end
            else if (rx_pos == 5)
            begin
                rsp_len[7:0] = b;
                rx_pos++;
            end
            else if (rx_pos == HDR_BYTES - 1)
            begin
                // unit byte: header verdict, first failing check wins
                if ({pdu_head[0], pdu_head[1]} != open_tid)
                    close_read(ST_ID_MISMATCH, 8'h00, 16'h0000);
                else if (pdu_head[2] != 8'h00 || pdu_head[3] != 8'h00)
                    close_read(ST_BAD_PROTOCOL, 8'h00, 16'h0000);
                else if (rsp_len < MIN_LENGTH)
                    close_read(ST_SHORT_LENGTH, 8'h00, 16'h0000);
                else if (int'(rsp_len) - 1 > PDU_BYTES)
                    close_read(ST_TOO_LARGE, 8'h00, 16'h0000);
                else
                begin
                    pdu_head = '{default: 8'h00};
                    rx_pos   = HDR_BYTES;
                end
            end
            else
            begin
                idx       = rx_pos - HDR_BYTES;
                remaining = int'(rsp_len) - 1;
                if (idx < 4)
                    pdu_head[idx] = b;
                if (idx + 1 < remaining)
                    rx_pos++;
                else if (pdu_head[0][EXC_FLAG_BIT])
                    close_read(ST_EXCEPTION, pdu_head[1], 16'h0000);
                else if (pdu_head[0] != FUNC_READ_HOLDING || pdu_head[1] != RSP_BYTE_COUNT ||
                         rsp_len < MIN_VALUE_LENGTH)
                    close_read(ST_UNEXPECTED, 8'h00, 16'h0000);
                else
                    close_read(ST_OK, 8'h00, {pdu_head[2], pdu_head[3]});
            end
        end
    endfunction

    task automatic check_word();
        out_word_t want;
        if (expected_words.size() == 0)
            report_mismatch("result word with nothing expected", m_axis_tdata[31:0], 32'h0);
        else
        begin
            want = expected_words.pop_front();
            if (m_axis_tuser !== want.kind)
                report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
            if (m_axis_tdata[7:0] !== want.tx_byte)
                report_mismatch("tx_byte", 32'(m_axis_tdata[7:0]), 32'(want.tx_byte));
            if (m_axis_tlast !== want.last)
                report_mismatch("last_byte", 32'(m_axis_tlast), 32'(want.last));
            if (m_axis_tdata[10:8] !== want.status)
                report_mismatch("status", 32'(m_axis_tdata[10:8]), 32'(want.status));
            if (m_axis_tdata[18:11] !== want.exc_code)
                report_mismatch("exception_code", 32'(m_axis_tdata[18:11]),
                                32'(want.exc_code));
            if (m_axis_tdata[34:19] !== want.reg_value)
                report_mismatch("register_value", 32'(m_axis_tdata[34:19]),
                                32'(want.reg_value));
            if (m_axis_tdata[39:35] !== 5'h00)
                report_mismatch("tdata padding", 32'(m_axis_tdata[39:35]), 32'h0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            unit_id    = 8'h00;
            next_tid   = 16'd1;
            open_tid   = 16'd0;
            busy_read  = 1'b0;
            rx_pos     = 0;
            rsp_len    = 16'h0000;
            pdu_head   = '{default: 8'h00};
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == ADDR_UNIT_ADDRESS)
                        unit_id = pwdata[7:0];
                end
                else if (prdata !== {24'h000000, unit_id})
                    report_mismatch("unit_address read", prdata, {24'h000000, unit_id});
            end
            // input first: a word accepted now cannot have its results out on the same edge
            if (s_axis_tvalid && s_axis_tready)
                predict_word(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            pending = expected_words.size();
        end
    end

endmodule

// File: sim/modbus_tcp_read_register_engine_tb.sv
// testbench top for the modbus tcp read-register engine
// drives apb writes and reads, start words and response frames with random stalls on both sides
// depends on mtrr_pkg, the engine rtl and mtrr_checker
`timescale 1ns / 1ps

module modbus_tcp_read_register_engine_tb;
    import mtrr_pkg::*;

    localparam int PDU_BYTES = 256;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {
        REPLY_OK,
        REPLY_EXCEPTION,
        REPLY_EXC_SHORT,
        REPLY_BAD_FUNC,
        REPLY_BAD_COUNT,
        REPLY_SHORT_PDU,
        REPLY_JUNK,
        REPLY_BAD_ID,
        REPLY_BAD_PROTO,
        REPLY_SHORT_LEN,
        REPLY_TOO_LARGE
    } reply_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = 32'h0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = 24'h0;   // register_address, rx_byte
    logic                  s_axis_tuser = 1'b0;    // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tx_byte, status, exception_code, register_value, zero pad
    logic [39:0]           m_axis_tdata;
    logic                  m_axis_tuser;           // kind
    logic                  m_axis_tlast;

    int          fail_count;
    int          pending;
    int          src_idle = 0;
    int          snk_idle = 0;
    logic        hold_req = 1'b0;
    int          words_sent = 0;
    logic [15:0] tid_counter = 16'd1;
    logic [15:0] last_tid = 16'd0;

    always #4 clk = ~clk;

    modbus_tcp_read_register_engine #(
        .PDU_BYTES(PDU_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    mtrr_checker #(
        .PDU_BYTES(PDU_BYTES)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_unit(input logic [7:0] unit);
        apb_access(1'b1, ADDR_UNIT_ADDRESS, {24'h0, unit});
        apb_access(1'b0, ADDR_UNIT_ADDRESS, 32'h0);
    endtask

    task automatic push_word(input logic cmd, input logic [15:0] addr, input logic [7:0] rxb,
                             input bit counted);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {rxb, addr};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        if (counted)
            words_sent++;
    endtask

    task automatic start_read(input logic [15:0] addr);
        push_word(CMD_START, addr, 8'($urandom_range(255)), 1'b1);
        last_tid    = tid_counter;
        tid_counter = tid_counter + 16'd1;
    endtask

    // one response frame; cut > 0 sends only that many bytes
    task automatic send_reply(input reply_kind_t rk, input logic [15:0] value, input int cut);
        logic [7:0]  pdu [$];
        logic [7:0]  frame [$];
        logic [7:0]  b;
        logic [15:0] tid;
        logic [15:0] proto;
        logic [15:0] len;
        int          extra;
        int          n;
        bit          header_only;
        tid         = last_tid;
        proto       = 16'h0000;
        header_only = 1'b0;
        extra       = 0;
        case (rk)
            REPLY_OK, REPLY_BAD_ID, REPLY_BAD_PROTO, REPLY_SHORT_LEN, REPLY_TOO_LARGE:
            begin
                pdu = {FUNC_READ_HOLDING, RSP_BYTE_COUNT, value[15:8], value[7:0]};
                n = $urandom_range(24);
                if (n == 0)
                    extra = PDU_BYTES - 4;
                else if (n == 1)
                    extra = $urandom_range(4, PDU_BYTES - 5);
                else
                    extra = $urandom_range(3);
            end
            REPLY_EXCEPTION:
            begin
                pdu = {8'h80 | 8'($urandom_range(127)), value[7:0]};
                extra = $urandom_range(2);
            end
            REPLY_EXC_SHORT:
                pdu = {8'h80 | 8'($urandom_range(127))};
            REPLY_BAD_FUNC:
            begin
                do b = 8'($urandom_range(127)); while (b == FUNC_READ_HOLDING);
                pdu = {b, RSP_BYTE_COUNT, value[15:8], value[7:0]};
            end
            REPLY_BAD_COUNT:
            begin
                do b = 8'($urandom_range(255)); while (b == RSP_BYTE_COUNT);
                pdu = {FUNC_READ_HOLDING, b, value[15:8], value[7:0]};
            end
            REPLY_SHORT_PDU:
            begin
                pdu = {FUNC_READ_HOLDING};
                n = $urandom_range(2);
                if (n > 0)
                    pdu.push_back(RSP_BYTE_COUNT);
                if (n > 1)
                    pdu.push_back(value[15:8]);
            end
            default:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    pdu.push_back(8'($urandom_range(255)));
            end
        endcase
        for (int i = 0; i < extra; i++)
            pdu.push_back(8'($urandom_range(255)));
        len = 16'(pdu.size() + 1);
        case (rk)
            REPLY_BAD_ID:
            begin
                tid = tid ^ (16'h1 << $urandom_range(15));
                header_only = 1'b1;
            end
            REPLY_BAD_PROTO:
            begin
                proto = 16'($urandom_range(1, 65535));
                header_only = 1'b1;
            end
            REPLY_SHORT_LEN:
            begin
                len = 16'($urandom_range(1));
                header_only = 1'b1;
            end
            REPLY_TOO_LARGE:
            begin
                n = $urandom_range(3);
                len = (n == 0) ? 16'hFFFF : (n == 1) ? 16'(PDU_BYTES + 2)
                                                     : 16'($urandom_range(PDU_BYTES + 2, 65535));
                header_only = 1'b1;
            end
            default:
                ;
        endcase
        frame = {tid[15:8], tid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0],
                 8'($urandom_range(255))};
        if (!header_only)
            frame = {frame, pdu};
        n = (cut > 0 && cut < frame.size()) ? cut : frame.size();
        for (int i = 0; i < n; i++)
            push_word(CMD_RX_BYTE, 16'($urandom_range(65535)), frame[i], 1'b1);
    endtask

    task automatic run_phase(input int target);
        int          first;
        int          r;
        reply_kind_t rk;
        first = words_sent;
        while (words_sent - first < target)
        begin
            // stray bytes; ignored unless a cut frame left a read open
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3))
                    push_word(CMD_RX_BYTE, 16'($urandom_range(65535)),
                              8'($urandom_range(255)), 1'b0);
            start_read(16'($urandom_range(65535)));
            r = $urandom_range(99);
            rk = (r < 35) ? REPLY_OK : (r < 47) ? REPLY_EXCEPTION :
                 (r < 52) ? REPLY_EXC_SHORT : (r < 58) ? REPLY_BAD_FUNC :
                 (r < 63) ? REPLY_BAD_COUNT : (r < 69) ? REPLY_SHORT_PDU :
                 (r < 74) ? REPLY_JUNK : (r < 79) ? REPLY_BAD_ID :
                 (r < 84) ? REPLY_BAD_PROTO : (r < 89) ? REPLY_SHORT_LEN :
                 (r < 94) ? REPLY_TOO_LARGE : REPLY_OK;
            // the last slice is cut short so the next start abandons it
            send_reply(rk, 16'($urandom_range(65535)), (r >= 94) ? $urandom_range(1, 10) : 0);
        end
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: stray byte, abandoned start, extreme value, one-byte exception pdu
        set_unit(8'h00);
        push_word(CMD_RX_BYTE, 16'hFFFF, 8'hFF, 1'b0);
        start_read(16'h0000);
        start_read(16'hFFFF);
        send_reply(REPLY_OK, 16'hFFFF, 0);
        start_read(16'h0000);
        send_reply(REPLY_EXC_SHORT, 16'h0000, 0);
        settle();

        src_idle = 36;
        snk_idle = 59;
        set_unit(8'hFF);
        run_phase(90);
        settle();

        src_idle = 59;
        snk_idle = 36;
        set_unit(8'($urandom_range(1, 254)));
        run_phase(80);
        settle();

        src_idle = 0;
        snk_idle = 0;
        set_unit(8'h5A);
        hold_req = 1'b1;
        run_phase(80);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
